[rtl/stw_pkg.sv]
// ----------------------------------------------------------------------------
// stw_pkg
// Shared types for the slot table: request and response words and the
// request codes.
// ----------------------------------------------------------------------------
package stw_pkg;

    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_FIND   = 2'd3
    } t_req_type;

    typedef struct packed {
        t_req_type   req_type;
        logic [5:0]  slot_index;
        logic [31:0] elem_data;
    } t_req;

    typedef struct packed {
        logic       ok;
        logic       found;
        logic [5:0] found_index;
        logic [6:0] occupied_now;
        logic [6:0] tail_now;
    } t_rsp;

endpackage

[rtl/stw_slot_ram.sv]
// ----------------------------------------------------------------------------
// stw_slot_ram
// Simple dual-port slot memory: one write port, one read port and
// registered read data.
// ----------------------------------------------------------------------------
module stw_slot_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/stw_ctrl.sv]
// ----------------------------------------------------------------------------
// stw_ctrl
// Request sequencer: owns the occupied count, the tail mark and the fill
// byte, drives the slot memory and runs the find and tail recovery scans.
// ----------------------------------------------------------------------------
module stw_ctrl
    import stw_pkg::*;
#(
    parameter int SLOTS      = 64,
    parameter int ELEM_BYTES = 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  t_req                     i_word,
    input  logic                     i_cfg_we,
    input  logic [7:0]               i_cfg_data,
    output logic                     o_res_valid,
    input  logic                     i_res_ready,
    output t_rsp                     o_res_word,
    output logic                     o_wr_en,
    output logic [$clog2(SLOTS)-1:0] o_wr_addr,
    output logic [8*ELEM_BYTES-1:0]  o_wr_data,
    output logic                     o_rd_en,
    output logic [$clog2(SLOTS)-1:0] o_rd_addr,
    input  logic [8*ELEM_BYTES-1:0]  i_rd_data
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int SW = 8 * ELEM_BYTES;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MODIFY,
        S_FIND,
        S_RECOVER,
        S_DONE
    } t_state;

    t_state          r_state, n_state;
    logic [IW-1:0]   r_ptr, n_ptr;
    logic [IW-1:0]   r_addr, n_addr;
    logic [SW-1:0]   r_key, n_key;
    logic [7:0]      r_fill, n_fill;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_tail, n_tail;
    logic            r_ok, n_ok;
    logic            r_found, n_found;
    logic [5:0]      r_fidx, n_fidx;

    logic [SW-1:0]   pattern;
    logic [SW-1:0]   in_key;
    logic            in_fire;
    logic            idx_in_range;
    logic            was_occ;
    logic            now_occ;

    assign pattern      = {ELEM_BYTES{r_fill}};
    assign in_key       = SW'(i_word.elem_data);
    assign o_ready      = (r_state == S_IDLE);
    assign in_fire      = i_valid && o_ready;
    assign idx_in_range = (32'(i_word.slot_index) < SLOTS);
    assign was_occ      = (i_rd_data != pattern);
    assign now_occ      = (r_key != pattern);

    assign o_res_valid             = (r_state == S_DONE);
    assign o_res_word.ok           = r_ok;
    assign o_res_word.found        = r_found;
    assign o_res_word.found_index  = r_fidx;
    assign o_res_word.occupied_now = 7'(r_count);
    assign o_res_word.tail_now     = 7'(r_tail);

    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        n_addr    = r_addr;
        n_key     = r_key;
        n_fill    = r_fill;
        n_count   = r_count;
        n_tail    = r_tail;
        n_ok      = r_ok;
        n_found   = r_found;
        n_fidx    = r_fidx;
        o_wr_en   = 1'b0;
        o_wr_addr = r_addr;
        o_wr_data = r_key;
        o_rd_en   = 1'b0;
        o_rd_addr = r_ptr + IW'(1);

        case (r_state)
            S_CLEAR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_ptr;
                o_wr_data = pattern;
                if (r_ptr == IW'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + IW'(1);
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    n_ok    = 1'b0;
                    n_found = 1'b0;
                    n_fidx  = '0;
                    n_key   = in_key;
                    case (i_word.req_type)
                        REQ_APPEND: begin
                            n_state = S_DONE;
                            if (r_tail < CW'(SLOTS)) begin
                                n_ok = 1'b1;
                                // The slot at the tail is always empty, so an
                                // empty element leaves the table as it is.
                                if (in_key != pattern) begin
                                    o_wr_en   = 1'b1;
                                    o_wr_addr = r_tail[IW-1:0];
                                    o_wr_data = in_key;
                                    n_count   = r_count + CW'(1);
                                    n_tail    = r_tail + CW'(1);
                                end
                            end
                        end
                        REQ_INSERT, REQ_REMOVE: begin
                            if (idx_in_range) begin
                                n_ok      = 1'b1;
                                o_rd_en   = 1'b1;
                                o_rd_addr = IW'(i_word.slot_index);
                                n_addr    = IW'(i_word.slot_index);
                                n_state   = S_MODIFY;
                                if (i_word.req_type == REQ_REMOVE) begin
                                    n_key = pattern;
                                end
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        REQ_FIND: begin
                            o_rd_en   = 1'b1;
                            o_rd_addr = '0;
                            n_ptr     = '0;
                            n_state   = S_FIND;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_MODIFY: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_addr;
                o_wr_data = r_key;
                n_state   = S_DONE;
                if (now_occ && !was_occ) begin
                    n_count = r_count + CW'(1);
                end else if (!now_occ && was_occ) begin
                    n_count = r_count - CW'(1);
                end
                if (now_occ) begin
                    if (CW'(r_addr) >= r_tail) begin
                        n_tail = CW'(r_addr) + CW'(1);
                    end
                end else if (CW'(r_addr) + CW'(1) == r_tail) begin
                    // The top slot was emptied: walk down for the new tail.
                    if (r_addr == '0) begin
                        n_tail = '0;
                    end else begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = r_addr - IW'(1);
                        n_ptr     = r_addr - IW'(1);
                        n_state   = S_RECOVER;
                    end
                end
            end
            S_RECOVER: begin
                if (was_occ) begin
                    n_tail  = CW'(r_ptr) + CW'(1);
                    n_state = S_DONE;
                end else if (r_ptr == '0) begin
                    n_tail  = '0;
                    n_state = S_DONE;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_ptr - IW'(1);
                    n_ptr     = r_ptr - IW'(1);
                end
            end
            S_FIND: begin
                if (i_rd_data == r_key) begin
                    n_ok    = 1'b1;
                    n_found = 1'b1;
                    n_fidx  = 6'(r_ptr);
                    n_state = S_DONE;
                end else if (r_ptr == IW'(SLOTS - 1)) begin
                    n_state = S_DONE;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_ptr + IW'(1);
                    n_ptr     = r_ptr + IW'(1);
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A new fill byte empties the table through a fresh clearing pass.
        if (i_cfg_we) begin
            n_fill  = i_cfg_data;
            n_count = '0;
            n_tail  = '0;
            n_ptr   = '0;
            n_state = S_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ptr   <= '0;
            r_fill  <= '0;
            r_count <= '0;
            r_tail  <= '0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_fill  <= n_fill;
            r_count <= n_count;
            r_tail  <= n_tail;
        end
        r_addr  <= n_addr;
        r_key   <= n_key;
        r_ok    <= n_ok;
        r_found <= n_found;
        r_fidx  <= n_fidx;
    end

    a_count_le_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_tail)
        else $error("occupied count exceeds tail mark");

    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail <= CW'(SLOTS))
        else $error("tail mark beyond capacity");

    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_state == S_CLEAR) && (r_count == '0) && (r_tail == '0))
        else $error("fill write did not restart the clearing pass");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_wr_en && o_rd_en && (o_wr_addr == o_rd_addr)))
        else $error("read and write of the same slot in one cycle");

endmodule

[rtl/slot_table_with_tail_and_find.sv]
// ----------------------------------------------------------------------------
// slot_table_with_tail_and_find
// Fixed-capacity slot table with occupied count, tail mark and linear find.
// ----------------------------------------------------------------------------
// Usage: requests arrive as words on the input valid/ready channel and each
// one produces exactly one response word on the output valid/ready channel,
// unless a fill write cuts it short. The table holds one request at a time.
// After acceptance an append is answered without a memory read, an insert
// or remove reads its slot and then writes it, and a remove that empties
// the top slot then reads down one slot at a time to the new tail (no reads
// when the top is slot 0). A find scans up from slot 0 to the lowest match,
// or to the last slot when nothing matches, reading one slot per cycle
// through the single read port of the slot memory; that port sets the rate.
// After reset, and after every write of the fill byte, a clearing pass
// writes the empty pattern into every slot, one slot per cycle; no request
// is accepted meanwhile, but fill writes are.
// The response sits in an output register, so the next request is taken
// while the receiver stalls; that request finishes and then waits until the
// register is free.
// ----------------------------------------------------------------------------
module slot_table_with_tail_and_find
    import stw_pkg::*;
#(
    parameter int SLOTS      = 64,
    parameter int ELEM_BYTES = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_req       i_word,
    output logic       o_valid,
    input  logic       i_ready,
    output t_rsp       o_word,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data
);

    localparam int IW = $clog2(SLOTS);
    localparam int SW = 8 * ELEM_BYTES;

    // Memory port between the sequencer and the slot store.
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [SW-1:0] wr_data;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic [SW-1:0] rd_data;

    // Finished response from the sequencer.
    logic res_valid;
    logic res_ready;
    t_rsp res_word;

    // Output register.
    logic r_out_valid;
    t_rsp r_out_word;

    stw_slot_ram #(
        .DEPTH (SLOTS),
        .WIDTH (SW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    stw_ctrl #(
        .SLOTS      (SLOTS),
        .ELEM_BYTES (ELEM_BYTES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_word      (i_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res_word  (res_word),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    // The register takes a new response when it is empty or being drained.
    assign res_ready = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_valid && res_ready) begin
            r_out_word <= res_word;
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out_word;

endmodule

[tb/slot_table_with_tail_and_find_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slot_table_with_tail_and_find_test
// Self-checking bench for the slot table. A shadow copy of the table predicts
// every response word (status, find result, count and tail), and each
// response is checked in order. Directed requests cover the corner cases,
// then several random phases run, each under its own fill byte and its own
// sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module slot_table_with_tail_and_find_test;
    import stw_pkg::*;

    localparam int SLOTS      = 64;
    localparam int ELEM_BYTES = 4;
    localparam int PHASE_LEN  = 255;
    localparam int LONG_HOLD  = 400;

    // The shadow table mirrors the slot contents, the count and the tail. It
    // computes the response due for each accepted request word and holds the
    // due responses in arrival order.
    class slot_table_shadow;
        logic [31:0] slots [SLOTS];
        logic [7:0]  fill;
        int unsigned count;
        int unsigned tail;
        t_rsp        rsp_due [$];
        int          mismatches;

        function logic [31:0] pattern();
            return {ELEM_BYTES{fill}};
        endfunction

        // A fill write wipes the table to the new empty pattern.
        function void set_fill(logic [7:0] f);
            fill  = f;
            foreach (slots[i]) slots[i] = pattern();
            count = 0;
            tail  = 0;
        endfunction

        function void store(int unsigned idx, logic [31:0] d);
            logic was_used;
            logic now_used;
            was_used  = slots[idx] != pattern();
            now_used  = d != pattern();
            slots[idx] = d;
            if (now_used && !was_used) begin
                count++;
            end else if (!now_used && was_used) begin
                count--;
            end
            if (now_used) begin
                if (idx >= tail) tail = idx + 1;
            end else if (idx + 1 == tail) begin
                // The top slot just went empty, so walk down to the new tail.
                while (tail > 0 && slots[tail - 1] == pattern()) tail--;
            end
        endfunction

        function void take_request(t_req r);
            t_rsp        e;
            int unsigned k;
            e = '0;
            case (r.req_type)
                REQ_APPEND: begin
                    if (tail < SLOTS) begin
                        store(tail, r.elem_data);
                        e.ok = 1'b1;
                    end
                end
                REQ_INSERT: begin
                    if (r.slot_index < SLOTS) begin
                        store(r.slot_index, r.elem_data);
                        e.ok = 1'b1;
                    end
                end
                REQ_REMOVE: begin
                    if (r.slot_index < SLOTS) begin
                        store(r.slot_index, pattern());
                        e.ok = 1'b1;
                    end
                end
                default: begin
                    for (k = 0; k < SLOTS; k++) begin
                        if (slots[k] == r.elem_data) begin
                            e.found       = 1'b1;
                            e.found_index = k[5:0];
                            break;
                        end
                    end
                    e.ok = e.found;
                end
            endcase
            e.occupied_now = count[6:0];
            e.tail_now     = tail[6:0];
            rsp_due.push_back(e);
        endfunction

        function void check_rsp(t_rsp got);
            t_rsp e;
            if (rsp_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: response word with none due: ok=%0b found=%0b idx=%0d occ=%0d tail=%0d",
                             $realtime, got.ok, got.found, got.found_index,
                             got.occupied_now, got.tail_now);
                end
                return;
            end
            e = rsp_due.pop_front();
            if (got.ok !== e.ok || got.found !== e.found ||
                got.found_index !== e.found_index ||
                got.occupied_now !== e.occupied_now || got.tail_now !== e.tail_now) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: mismatch exp ok=%0b found=%0b idx=%0d occ=%0d tail=%0d",
                             $realtime, e.ok, e.found, e.found_index,
                             e.occupied_now, e.tail_now);
                    $display("%0t:          got ok=%0b found=%0b idx=%0d occ=%0d tail=%0d",
                             $realtime, got.ok, got.found, got.found_index,
                             got.occupied_now, got.tail_now);
                end
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    t_req       i_word;
    logic       o_valid;
    logic       i_ready;
    t_rsp       o_word;
    logic       i_cfg_we;
    logic [7:0] i_cfg_data;

    slot_table_shadow shadow = new();

    // Sender burst control and the receiver's stall pattern. The main process
    // sets these; the receiver process only reads them.
    bit          tx_gaps;
    int          burst_left;
    int          rx_period;
    int          rx_low;
    int          hold_ticket;
    logic [31:0] elem_pool [8];

    // Receiver-owned counters.
    int          rx_count;
    int          hold_taken;
    int          hold_left;

    slot_table_with_tail_and_find #(
        .SLOTS      (SLOTS),
        .ELEM_BYTES (ELEM_BYTES)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_word     (i_word),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_word     (o_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Receiver: a periodic stall pattern, overridden by a long hold-off each
    // time the main process bumps the hold ticket. The hold is counted here.
    always @(posedge i_clk) begin
        if (hold_taken != hold_ticket) begin
            hold_taken = hold_ticket;
            hold_left  = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            rx_count = (rx_count + 1) % rx_period;
            i_ready <= (rx_count >= rx_low);
        end
    end

    // Monitor: every handshake and fill write is fed to the shadow table at
    // the edge where it happens.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) shadow.set_fill(i_cfg_data);
            if (i_valid && o_ready) shadow.take_request(i_word);
            if (o_valid && i_ready) shadow.check_rsp(o_word);
        end
    end

    // Offer one request word and return at the edge where it is taken. Valid
    // stays high into the next call unless a gap is due.
    task automatic send_request(input t_req r);
        int gap;
        if (tx_gaps && burst_left <= 0) begin
            gap = $urandom_range(1, 12);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        i_valid <= 1'b1;
        i_word  <= r;
        do @(posedge i_clk); while (!o_ready);
        burst_left--;
    endtask

    task automatic send_op(input t_req_type op, input logic [5:0] idx,
                           input logic [31:0] d);
        t_req r;
        r.req_type   = op;
        r.slot_index = idx;
        r.elem_data  = d;
        send_request(r);
    endtask

    // Stop offering and wait until every due response has come back.
    task automatic drain();
        i_valid <= 1'b0;
        while (shadow.rsp_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Elements lean toward the empty pattern, near misses of it, and a small
    // pool of repeated values so that finds hit and inserts overwrite.
    function automatic logic [31:0] pick_elem();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return shadow.pattern();
        if (r < 22) return shadow.pattern() ^ (32'h1 << $urandom_range(0, 31));
        if (r < 55) return elem_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int          p;
        int          n;
        int          pick;
        int          tail_hint;
        t_req_type   op;
        logic [5:0]  idx;
        logic [7:0]  phase_fill;

        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_word     <= '0;
        i_ready    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= 8'h00;
        tx_gaps     = 1'b1;
        burst_left  = 0;
        rx_period   = 3;
        rx_low      = 1;
        hold_ticket = 0;
        hold_taken  = 0;
        hold_left   = 0;
        rx_count    = 0;
        shadow.mismatches = 0;
        shadow.set_fill(8'h00);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corner cases with the reset fill byte of zero.
        send_op(REQ_FIND,   6'd0,  32'h0000_0000);  // empty pattern hits slot 0
        send_op(REQ_FIND,   6'd0,  32'hFFFF_FFFF);  // miss on an empty table
        send_op(REQ_APPEND, 6'd0,  32'h0000_0001);
        send_op(REQ_APPEND, 6'd0,  32'h0000_0000);  // empty append: ok, no change
        send_op(REQ_INSERT, 6'd63, 32'hFFFF_FFFF);  // tail jumps to capacity
        send_op(REQ_APPEND, 6'd0,  32'hDEAD_BEEF);  // append on a full tail fails
        send_op(REQ_INSERT, 6'd63, 32'h8000_0000);  // overwrite, count unchanged
        send_op(REQ_FIND,   6'd0,  32'h8000_0000);  // match in the top slot
        send_op(REQ_INSERT, 6'd10, 32'h1234_5678);
        send_op(REQ_REMOVE, 6'd63, 32'h0000_0000);  // tail walks down to 11
        send_op(REQ_REMOVE, 6'd63, 32'hFFFF_FFFF);  // removing an empty slot
        send_op(REQ_INSERT, 6'd10, 32'h0000_0000);  // empty insert acts as clear
        send_op(REQ_FIND,   6'd0,  32'h0000_0001);
        send_op(REQ_REMOVE, 6'd0,  32'h0000_0000);  // table back to empty
        send_op(REQ_REMOVE, 6'd0,  32'h0000_0000);
        send_op(REQ_APPEND, 6'd0,  32'h0000_0000);
        send_op(REQ_INSERT, 6'd0,  32'hFFFF_FFFF);
        send_op(REQ_FIND,   6'd0,  32'h0000_0000);  // lowest empty slot is 1

        for (p = 0; p < 6; p++) begin
            drain();
            case (p)
                0:       phase_fill = 8'hFF;
                1:       phase_fill = 8'h00;
                3:       phase_fill = 8'hA5;
                4:       phase_fill = 8'h5A;
                default: phase_fill = 8'($urandom_range(1, 254));
            endcase
            // In one phase a throwaway fill lands first, during nothing but
            // the idle table, and the real one follows on the next edge.
            i_cfg_we   <= 1'b1;
            i_cfg_data <= (p == 4) ? 8'($urandom) : phase_fill;
            @(posedge i_clk);
            if (p == 4) begin
                i_cfg_data <= phase_fill;
                @(posedge i_clk);
            end
            i_cfg_we <= 1'b0;

            elem_pool[0] = 32'h0000_0000;
            elem_pool[1] = 32'hFFFF_FFFF;
            for (n = 2; n < 8; n++) elem_pool[n] = $urandom;

            // Phase 5 runs with no idling on either side; phase 2 keeps the
            // sender busy so the long receiver hold-off backs the table up.
            tx_gaps = (p != 2 && p != 5);
            if (p == 5) begin
                rx_period = 1;
                rx_low    = 0;
            end else begin
                rx_period = $urandom_range(2, 16);
                rx_low    = $urandom_range(0, rx_period - 1);
            end

            for (n = 0; n < PHASE_LEN; n++) begin
                if (p == 2 && n == 100) hold_ticket++;
                if (p == 3 && n == 120) drain();

                pick = $urandom_range(0, 99);
                if (p == 1 && n < 70) begin
                    op = REQ_APPEND;
                end else if (n < PHASE_LEN * 55 / 100) begin
                    // Growing half: mostly appends and inserts.
                    op = (pick < 45) ? REQ_APPEND : (pick < 65) ? REQ_INSERT :
                         (pick < 75) ? REQ_REMOVE : REQ_FIND;
                end else begin
                    // Shrinking half: removes are the most common request; they drive tail recovery.
                    op = (pick < 10) ? REQ_APPEND : (pick < 25) ? REQ_INSERT :
                         (pick < 70) ? REQ_REMOVE : REQ_FIND;
                end

                tail_hint = shadow.tail;
                case ($urandom_range(0, 3))
                    0, 1:    idx = 6'($urandom_range(0, SLOTS - 1));
                    2:       idx = (tail_hint == 0) ? 6'd0 : 6'(tail_hint - 1);
                    default: idx = $urandom_range(0, 1) ? 6'd63 : 6'd0;
                endcase
                send_op(op, idx, pick_elem());
            end
        end

        drain();
        repeat (SLOTS + 8) @(posedge i_clk);
        if (shadow.mismatches == 0 && shadow.rsp_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
